/* sv/esc_pkg.sv */
// Shared constants for the exponential soft clipper with dry/wet blend.
// Holds parameter defaults, table format, register indexes and pipeline depth.
// No dependencies.
package esc_pkg;

  // Defaults for the top-level parameters.
  localparam int SampleBitsDef = 16;
  localparam int ExpEntriesDef = 256;

  // Exponential table format: entries carry 24 fraction bits, up to e.
  localparam int TabFrac  = 24;
  localparam int TabW     = 26;

  // Taylor series used to fill the table at elaboration.
  localparam int SerFrac  = 50;
  localparam int SerTerms = 25;

  // Configuration register indexes.
  localparam int CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgThreshold = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgMix       = 1'd1;

  // Register stages from input to output register.
  localparam int PipeDepth = 8;

endpackage

/* sv/esc_index.sv */
// Front end of the clipper: picks the curve branch and locates the table segment.
// Two register stages. Depends on esc_pkg.
module esc_index #(
  parameter int SAMPLE_BITS       = esc_pkg::SampleBitsDef,
  parameter int EXP_TABLE_ENTRIES = esc_pkg::ExpEntriesDef
) (
  input  logic                                       clk_i,
  input  logic                                       en_i,
  input  logic [SAMPLE_BITS-2:0]                     threshold_i,
  input  logic signed [SAMPLE_BITS-1:0]              sample_i,
  output logic signed [SAMPLE_BITS-1:0]              x_o,
  output logic                                       sel_o,
  output logic [$clog2(EXP_TABLE_ENTRIES+1)-1:0]     idx_o,
  output logic [SAMPLE_BITS-1:0]                     fr_o
);
  import esc_pkg::*;

  localparam int SB   = SAMPLE_BITS;
  localparam int Frac = SB - 1;
  localparam int IdxW = $clog2(EXP_TABLE_ENTRIES + 1);
  localparam int PosW = SB + IdxW;
  localparam logic signed [SB:0] OneE = (SB + 1)'(1) << Frac;

  logic signed [SB-1:0] thr_s;
  logic signed [SB:0]   x_ext;
  logic signed [SB:0]   u_full;
  logic                 sel_d;
  logic [SB-1:0]        u_d;

  logic signed [SB-1:0] x1_q;
  logic                 sel1_q;
  logic [SB-1:0]        u1_q;

  logic [PosW-1:0]      pos;
  logic signed [SB-1:0] x2_q;
  logic                 sel2_q;
  logic [IdxW-1:0]      idx_q;
  logic [SB-1:0]        fr_q;

  // Stage 1: branch select and offset of the exponent argument into [0, 2*ONE).
  assign thr_s  = signed'({1'b0, threshold_i});
  assign sel_d  = sample_i > thr_s;
  assign x_ext  = signed'({sample_i[SB-1], sample_i});
  assign u_full = sel_d ? (OneE - x_ext) : (x_ext + OneE);
  assign u_d    = u_full[SB-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x1_q   <= sample_i;
      sel1_q <= sel_d;
      u1_q   <= u_d;
    end
  end

  // Stage 2: scale by the table size; the span 2*ONE is a power of two.
  assign pos = PosW'(u1_q) * PosW'(EXP_TABLE_ENTRIES);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x2_q   <= x1_q;
      sel2_q <= sel1_q;
      idx_q  <= pos[PosW-1:SB];
      fr_q   <= pos[SB-1:0];
    end
  end

  assign x_o   = x2_q;
  assign sel_o = sel2_q;
  assign idx_o = idx_q;
  assign fr_o  = fr_q;

endmodule

/* sv/esc_exp.sv */
// Exponential unit: table lookup, linear interpolation and conversion to sample format.
// Three register stages; the table is filled at elaboration. Depends on esc_pkg.
module esc_exp #(
  parameter int SAMPLE_BITS       = esc_pkg::SampleBitsDef,
  parameter int EXP_TABLE_ENTRIES = esc_pkg::ExpEntriesDef
) (
  input  logic                                       clk_i,
  input  logic                                       en_i,
  input  logic signed [SAMPLE_BITS-1:0]              x_i,
  input  logic                                       sel_i,
  input  logic [$clog2(EXP_TABLE_ENTRIES+1)-1:0]     idx_i,
  input  logic [SAMPLE_BITS-1:0]                     fr_i,
  output logic signed [SAMPLE_BITS-1:0]              x_o,
  output logic                                       sel_o,
  output logic [SAMPLE_BITS:0]                       e_o
);
  import esc_pkg::*;

  localparam int SB    = SAMPLE_BITS;
  localparam int Frac  = SB - 1;
  localparam int IdxW  = $clog2(EXP_TABLE_ENTRIES + 1);
  localparam int EW    = SB + 1;
  localparam int ProdW = TabW + SB;
  localparam int WideW = TabW + SB;
  localparam int UpSh  = (Frac >= TabFrac) ? (Frac - TabFrac) : 0;
  localparam int DnSh  = (Frac < TabFrac) ? (TabFrac - Frac) : 1;

  // Floor division by a small series index.
  function automatic logic [63:0] div_small(input logic [63:0] a, input int n);
    case (n)
      1:       return a;
      2:       return a / 2;
      3:       return a / 3;
      4:       return a / 4;
      5:       return a / 5;
      6:       return a / 6;
      7:       return a / 7;
      8:       return a / 8;
      9:       return a / 9;
      10:      return a / 10;
      11:      return a / 11;
      12:      return a / 12;
      13:      return a / 13;
      14:      return a / 14;
      15:      return a / 15;
      16:      return a / 16;
      17:      return a / 17;
      18:      return a / 18;
      19:      return a / 19;
      20:      return a / 20;
      21:      return a / 21;
      22:      return a / 22;
      23:      return a / 23;
      24:      return a / 24;
      25:      return a / 25;
      default: return a;
    endcase
  endfunction

  // One table entry: exp(-1 + 2k/N) from a truncated Taylor series, rounded to 24 bits.
  // Dividing by N and then by n floors the same as dividing by N*n.
  function automatic logic [TabW-1:0] exp_entry(input int k);
    int          num;
    logic        neg;
    logic [63:0] mag;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] sum_r;
    num  = 2 * k - EXP_TABLE_ENTRIES;
    neg  = (num < 0);
    mag  = neg ? 64'(-num) : 64'(num);
    term = 64'(1) << SerFrac;
    sum  = term;
    for (int n = 1; n <= SerTerms; n++) begin
      term = div_small((term * mag) / 64'(EXP_TABLE_ENTRIES), n);
      if (neg && n[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    sum_r = (sum + (64'(1) << (SerFrac - TabFrac - 1))) >> (SerFrac - TabFrac);
    return sum_r[TabW-1:0];
  endfunction

  logic [TabW-1:0] rom [EXP_TABLE_ENTRIES+1];

  for (genvar k = 0; k <= EXP_TABLE_ENTRIES; k++) begin : g_rom
    localparam logic [TabW-1:0] Entry = exp_entry(k);
    assign rom[k] = Entry;
  end

  logic [IdxW-1:0]      idx_hi;
  logic [TabW-1:0]      lo_d;
  logic [TabW-1:0]      hi_d;
  logic [TabW-1:0]      diff_d;

  logic signed [SB-1:0] x3_q;
  logic                 sel3_q;
  logic [TabW-1:0]      lo3_q;
  logic [TabW-1:0]      diff3_q;
  logic [SB-1:0]        fr3_q;

  logic [ProdW-1:0]     prod;
  logic signed [SB-1:0] x4_q;
  logic                 sel4_q;
  logic [TabW-1:0]      lo4_q;
  logic [TabW-1:0]      step4_q;

  logic [TabW-1:0]      v;
  logic [EW-1:0]        e_d;
  logic signed [SB-1:0] x5_q;
  logic                 sel5_q;
  logic [EW-1:0]        e5_q;

  // Stage 3: read both neighbors of the segment.
  assign idx_hi = IdxW'(idx_i + 1'b1);
  assign lo_d   = rom[idx_i];
  assign hi_d   = rom[idx_hi];
  assign diff_d = (hi_d >= lo_d) ? (hi_d - lo_d) : '0;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x3_q    <= x_i;
      sel3_q  <= sel_i;
      lo3_q   <= lo_d;
      diff3_q <= diff_d;
      fr3_q   <= fr_i;
    end
  end

  // Stage 4: interpolation step, floored over the power-of-two span.
  assign prod = ProdW'(diff3_q) * ProdW'(fr3_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x4_q    <= x3_q;
      sel4_q  <= sel3_q;
      lo4_q   <= lo3_q;
      step4_q <= prod[ProdW-1:SB];
    end
  end

  // Stage 5: interpolated value, moved to the sample's fraction bits.
  assign v = lo4_q + step4_q;

  if (Frac >= TabFrac) begin : g_up
    assign e_d = EW'(WideW'(v) << UpSh);
  end else begin : g_dn
    assign e_d = EW'((WideW'(v) + (WideW'(1) << (DnSh - 1))) >> DnSh);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x5_q   <= x4_q;
      sel5_q <= sel4_q;
      e5_q   <= e_d;
    end
  end

  assign x_o   = x5_q;
  assign sel_o = sel5_q;
  assign e_o   = e5_q;

endmodule

/* sv/esc_blend.sv */
// Back end of the clipper: shaped value, dry/wet products and rounded, saturated sum.
// Three register stages, the last being the output register. Depends on esc_pkg.
module esc_blend #(
  parameter int SAMPLE_BITS = esc_pkg::SampleBitsDef
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic signed [SAMPLE_BITS-1:0] x_i,
  input  logic                          sel_i,
  input  logic [SAMPLE_BITS:0]          e_i,
  input  logic [SAMPLE_BITS-1:0]        wet_i,
  input  logic [SAMPLE_BITS-1:0]        dry_i,
  output logic signed [SAMPLE_BITS-1:0] sample_o
);
  import esc_pkg::*;

  localparam int SB   = SAMPLE_BITS;
  localparam int Frac = SB - 1;
  localparam int ShW  = SB + 2;
  localparam int AccW = 2 * SB + 2;

  localparam logic signed [ShW-1:0]  ShOne  = ShW'(1) << Frac;
  localparam logic signed [ShW-1:0]  ShMax  = ShOne - ShW'(1);
  localparam logic signed [ShW-1:0]  ShMin  = ~ShMax;
  localparam logic signed [AccW-1:0] AccMax = (AccW'(1) << Frac) - AccW'(1);
  localparam logic signed [AccW-1:0] AccMin = ~AccMax;
  localparam logic signed [AccW-1:0] Half   = AccW'(1) << (Frac - 1);

  logic signed [ShW-1:0]  e_s;
  logic signed [ShW-1:0]  raw_sh;
  logic signed [SB-1:0]   sh_d;
  logic signed [SB-1:0]   x6_q;
  logic signed [SB-1:0]   sh6_q;

  logic signed [AccW-1:0] pw_d;
  logic signed [AccW-1:0] pd_d;
  logic signed [AccW-1:0] pw7_q;
  logic signed [AccW-1:0] pd7_q;

  logic signed [AccW-1:0] rnd;
  logic signed [SB-1:0]   out_d;
  logic signed [SB-1:0]   out_q;

  // Stage 6: pick the curve branch and clamp it to the sample range.
  assign e_s    = signed'({1'b0, e_i});
  assign raw_sh = sel_i ? (ShOne - e_s) : (e_s - ShOne);

  always_comb begin
    if (raw_sh > ShMax) begin
      sh_d = SB'(ShMax);
    end else if (raw_sh < ShMin) begin
      sh_d = SB'(ShMin);
    end else begin
      sh_d = SB'(raw_sh);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x6_q  <= x_i;
      sh6_q <= sh_d;
    end
  end

  // Stage 7: wet and dry products; the weights are nonnegative.
  assign pw_d = AccW'(sh6_q) * AccW'(signed'({1'b0, wet_i}));
  assign pd_d = AccW'(x6_q) * AccW'(signed'({1'b0, dry_i}));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pw7_q <= pw_d;
      pd7_q <= pd_d;
    end
  end

  // Stage 8: round half up, floor shift and saturate into the output register.
  assign rnd = (pw7_q + pd7_q + Half) >>> Frac;

  always_comb begin
    if (rnd > AccMax) begin
      out_d = SB'(AccMax);
    end else if (rnd < AccMin) begin
      out_d = SB'(AccMin);
    end else begin
      out_d = SB'(rnd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q <= out_d;
    end
  end

  assign sample_o = out_q;

endmodule

/* sv/exponential_soft_clipper_mix_top.sv */
// Top level of the exponential soft clipper with dry/wet blend.
// Instantiates esc_index, esc_exp and esc_blend; depends on esc_pkg.
//
// Usage:
// - Input stream s_axis_*: one signed Q1.15 sample per request in tdata.
// - Output stream m_axis_*: one blended, saturated sample per input request.
// - Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
//   (0 = threshold, 1 = mix) at the clock edge. Write only while no sample
//   is in flight.
// - From an accepted input request to the output register, the stages are
//   branch select, table scaling, table read, interpolation multiply,
//   format conversion, curve clamp, blend multiply and rounding.
// - Throughput is one sample per cycle unless stalled; every stage holds one sample.
// - Reset clears all stage valid bits and sets threshold and mix to zero,
//   so a fresh block passes the dry signal unchanged.
// - When the receiver stalls with a result waiting, the whole pipeline
//   holds and s_axis_tready drops; nothing is lost or repeated. Bubbles
//   are carried through, not squeezed out.
module exponential_soft_clipper_mix_top #(
  parameter int SAMPLE_BITS       = esc_pkg::SampleBitsDef,
  parameter int EXP_TABLE_ENTRIES = esc_pkg::ExpEntriesDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Input stream; tdata: sample_in
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_axis_tdata,
  // Output stream; tdata: sample_out
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]     m_axis_tdata,
  // Configuration write port
  input  logic                                 cfg_we_i,
  input  logic [esc_pkg::CfgIdxW-1:0]          cfg_idx_i,
  input  logic [SAMPLE_BITS-1:0]               cfg_data_i
);
  import esc_pkg::*;

  localparam int SB    = SAMPLE_BITS;
  localparam int Frac  = SB - 1;
  localparam int DataW = ((SB + 7) / 8) * 8;
  localparam int IdxW  = $clog2(EXP_TABLE_ENTRIES + 1);
  localparam logic [SB-1:0] OneQ = SB'(1) << Frac;

  logic [SB-2:0]        threshold_q;
  logic [SB-1:0]        wet_q;
  logic [SB-1:0]        dry_q;
  logic [SB-1:0]        wet_d;

  logic                 en;
  logic [PipeDepth-1:0] vld_q;

  logic signed [SB-1:0] sample_in;
  logic signed [SB-1:0] x_a;
  logic                 sel_a;
  logic [IdxW-1:0]      idx_a;
  logic [SB-1:0]        fr_a;
  logic signed [SB-1:0] x_b;
  logic                 sel_b;
  logic [SB:0]          e_b;
  logic signed [SB-1:0] sample_out;

  // Configuration registers; mix above one acts as one.
  assign wet_d = (cfg_data_i > OneQ) ? OneQ : cfg_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= '0;
      wet_q       <= '0;
      dry_q       <= OneQ;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgThreshold: threshold_q <= cfg_data_i[SB-2:0];
        CfgMix: begin
          wet_q <= wet_d;
          dry_q <= OneQ - wet_d;
        end
        default: ;
      endcase
    end
  end

  // Global advance: the pipeline moves unless a result waits on a stalled receiver.
  assign en            = !vld_q[PipeDepth-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[PipeDepth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PipeDepth-2:0], s_axis_tvalid};
    end
  end

  assign sample_in = signed'(s_axis_tdata[SB-1:0]);

  esc_index #(
    .SAMPLE_BITS       (SAMPLE_BITS),
    .EXP_TABLE_ENTRIES (EXP_TABLE_ENTRIES)
  ) u_index (
    .clk_i       (clk_i),
    .en_i        (en),
    .threshold_i (threshold_q),
    .sample_i    (sample_in),
    .x_o         (x_a),
    .sel_o       (sel_a),
    .idx_o       (idx_a),
    .fr_o        (fr_a)
  );

  esc_exp #(
    .SAMPLE_BITS       (SAMPLE_BITS),
    .EXP_TABLE_ENTRIES (EXP_TABLE_ENTRIES)
  ) u_exp (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (x_a),
    .sel_i (sel_a),
    .idx_i (idx_a),
    .fr_i  (fr_a),
    .x_o   (x_b),
    .sel_o (sel_b),
    .e_o   (e_b)
  );

  esc_blend #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_blend (
    .clk_i    (clk_i),
    .en_i     (en),
    .x_i      (x_b),
    .sel_i    (sel_b),
    .e_i      (e_b),
    .wet_i    (wet_q),
    .dry_i    (dry_q),
    .sample_o (sample_out)
  );

  // Output data, zero-filled to whole bytes.
  assign m_axis_tdata = DataW'($unsigned(sample_out));

endmodule

/* test/tb_top.sv */
// Self-checking testbench for exponential_soft_clipper_mix_top.
// A stream driver and a stream monitor run against an in-bench model of the
// table-based exponential clipper and blend; depends on esc_pkg and the RTL.
module tb_top;

  localparam int SampleW     = esc_pkg::SampleBitsDef;
  localparam int TdataW      = ((SampleW + 7) / 8) * 8;
  localparam int Frac        = SampleW - 1;
  localparam int Entries     = esc_pkg::ExpEntriesDef;
  localparam longint One     = longint'(1) << Frac;
  localparam int LimitCycles = 500000;

  // Kinds of entries in the request plan.
  typedef enum logic [1:0] {
    ACT_SAMPLE,
    ACT_CFG,
    ACT_DRAIN
  } act_kind_e;

  typedef struct {
    act_kind_e                    kind;
    logic [esc_pkg::CfgIdxW-1:0]  idx;
    logic [SampleW-1:0]           data;
    int                           gap;
    bit                           calm;
  } plan_item_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [TdataW-1:0]            s_axis_tdata  = '0;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [TdataW-1:0]            m_axis_tdata;
  logic                         cfg_we_i      = 1'b0;
  logic [esc_pkg::CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [SampleW-1:0]           cfg_data_i    = '0;

  // Request plan, expected blended samples and the shadow of the registers.
  plan_item_t          plan_q[$];
  logic [SampleW-1:0]  blended_q[$];
  logic [Frac-1:0]     thr_r = '0;
  logic [SampleW-1:0]  mix_r = '0;
  longint unsigned     exp_tab[0:Entries];

  int  err_cnt   = 0;
  int  gap_cnt   = 0;
  int  stall_cnt = 0;
  bit  sink_calm = 1'b0;
  bit  idle_mode = 1'b1;

  exponential_soft_clipper_mix_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // tdata: sample_in
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // tdata: sample_out
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    err_cnt++;
  endtask

  function automatic longint saturate_sample(longint v);
    if (v > One - 1) begin
      return One - 1;
    end
    if (v < -One) begin
      return -One;
    end
    return v;
  endfunction

  // exp(t / One) for t in [-One, One), interpolated from the table.
  function automatic longint exp_lookup(longint t);
    longint unsigned span, pos, idx, fr, lo, hi, v;
    span = longint'(2) * One;
    pos  = unsigned'(t + One) * Entries;
    idx  = pos / span;
    fr   = pos % span;
    if (idx >= Entries) begin
      idx = Entries - 1;
      fr  = span - 1;
    end
    lo = exp_tab[idx];
    hi = exp_tab[idx + 1];
    v  = lo + ((hi >= lo) ? ((hi - lo) * fr) / span : 64'd0);
    return longint'((v + (64'd1 << (esc_pkg::TabFrac - Frac - 1)))
                    >> (esc_pkg::TabFrac - Frac));
  endfunction

  // Shape one sample on the branch picked by the threshold, then blend.
  function automatic logic [SampleW-1:0] clip_mix_sample(logic [SampleW-1:0] raw);
    longint x, shaped, m, acc, q;
    x = longint'($signed(raw));
    if (x > longint'(thr_r)) begin
      shaped = One - exp_lookup(-x);
    end else begin
      shaped = exp_lookup(x) - One;
    end
    shaped = saturate_sample(shaped);
    m   = (longint'(mix_r) > One) ? One : longint'(mix_r);
    acc = x * (One - m) + shaped * m;
    q   = saturate_sample((acc + (One >>> 1)) >>> Frac);
    return q[SampleW-1:0];
  endfunction

  task automatic add_sample(logic [SampleW-1:0] s);
    plan_item_t it;
    it.kind = ACT_SAMPLE;
    it.idx  = '0;
    it.data = s;
    it.gap  = (idle_mode && $urandom_range(0, 7) == 0) ? $urandom_range(1, 12) : 0;
    it.calm = !idle_mode;
    plan_q.push_back(it);
  endtask

  task automatic add_cfg(logic [esc_pkg::CfgIdxW-1:0] idx, logic [SampleW-1:0] d);
    plan_item_t it;
    it.kind = ACT_CFG;
    it.idx  = idx;
    it.data = d;
    it.gap  = 0;
    it.calm = !idle_mode;
    plan_q.push_back(it);
  endtask

  task automatic add_drain();
    plan_item_t it;
    it.kind = ACT_DRAIN;
    it.idx  = '0;
    it.data = '0;
    it.gap  = 0;
    it.calm = !idle_mode;
    plan_q.push_back(it);
  endtask

  // Driver: presents samples, predicts each accepted one, writes registers
  // only once every expected result has come back.
  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    logic                         sent;
    logic                         nv;
    logic [SampleW-1:0]           nd;
    logic                         nwe;
    logic [esc_pkg::CfgIdxW-1:0]  nidx;
    logic [SampleW-1:0]           ncd;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      cfg_we_i      <= 1'b0;
      gap_cnt = 0;
    end else begin
      sent = s_axis_tvalid && s_axis_tready;
      if (sent) begin
        blended_q.push_back(clip_mix_sample(s_axis_tdata[SampleW-1:0]));
      end
      nv   = s_axis_tvalid && !sent;
      nd   = s_axis_tdata[SampleW-1:0];
      nwe  = 1'b0;
      nidx = cfg_idx_i;
      ncd  = cfg_data_i;
      if (!nv) begin
        if (gap_cnt > 0) begin
          gap_cnt--;
        end else if (plan_q.size() > 0) begin
          case (plan_q[0].kind)
            ACT_SAMPLE: begin
              if (plan_q[0].gap > 0) begin
                gap_cnt = plan_q[0].gap - 1;
                plan_q[0].gap = 0;
              end else begin
                nv = 1'b1;
                nd = plan_q[0].data;
                sink_calm <= plan_q[0].calm;
                void'(plan_q.pop_front());
              end
            end
            ACT_CFG: begin
              if (blended_q.size() == 0) begin
                nwe  = 1'b1;
                nidx = plan_q[0].idx;
                ncd  = plan_q[0].data;
                if (plan_q[0].idx == esc_pkg::CfgThreshold) begin
                  thr_r = plan_q[0].data[Frac-1:0];
                end else if (plan_q[0].idx == esc_pkg::CfgMix) begin
                  mix_r = plan_q[0].data;
                end
                void'(plan_q.pop_front());
              end
            end
            default: begin
              if (blended_q.size() == 0) begin
                void'(plan_q.pop_front());
              end
            end
          endcase
        end
      end
      s_axis_tvalid <= nv;
      s_axis_tdata  <= TdataW'(nd);
      cfg_we_i      <= nwe;
      cfg_idx_i     <= nidx;
      cfg_data_i    <= ncd;
    end
  end

  // Monitor: checks each accepted result and stalls the output in bursts.
  always @(posedge clk_i or negedge rst_ni) begin : watch_proc
    logic [SampleW-1:0] want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_cnt = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (blended_q.size() == 0) begin
          report_mismatch($sformatf("unexpected sample_out %0d",
                                    $signed(m_axis_tdata[SampleW-1:0])));
        end else begin
          want = blended_q.pop_front();
          if (m_axis_tdata[SampleW-1:0] !== want) begin
            report_mismatch($sformatf("sample_out got %0d want %0d",
                                      $signed(m_axis_tdata[SampleW-1:0]),
                                      $signed(want)));
          end
        end
      end
      if (stall_cnt > 0) begin
        stall_cnt--;
        m_axis_tready <= 1'b0;
      end else if (!sink_calm && $urandom_range(0, 9) == 0) begin
        stall_cnt = $urandom_range(1, 12) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Stimulus plan, reset and the end of the run.
  initial begin : main_proc
    longint unsigned  term, total, mag;
    longint           num;
    bit               neg;
    logic [Frac-1:0]  thr_pick;
    logic [SampleW-1:0] mix_pick, s;
    int               cnt;

    // Exponential table from a truncated Taylor series, as the block builds it.
    for (int k = 0; k <= Entries; k++) begin
      num   = 2 * longint'(k) - Entries;
      neg   = num < 0;
      mag   = neg ? unsigned'(-num) : unsigned'(num);
      term  = 64'd1 << esc_pkg::SerFrac;
      total = term;
      for (int n = 1; n <= esc_pkg::SerTerms; n++) begin
        term = (term * mag) / (longint'(Entries) * n);
        if (neg && (n % 2 == 1)) begin
          total = total - term;
        end else begin
          total = total + term;
        end
      end
      exp_tab[k] = (total + (64'd1 << (esc_pkg::SerFrac - esc_pkg::TabFrac - 1)))
                   >> (esc_pkg::SerFrac - esc_pkg::TabFrac);
    end

    // Directed: reset settings pass the dry signal through.
    add_sample(16'h8000);
    add_sample(16'h7fff);
    add_sample(16'h0000);
    add_sample(16'h0001);
    add_sample(16'hffff);
    // Highest threshold, written with the unused top bit set; fully wet,
    // so exp(x)-1 overflows and saturates at the top.
    add_cfg(esc_pkg::CfgThreshold, 16'hffff);
    add_cfg(esc_pkg::CfgMix, 16'h8000);
    add_sample(16'h7fff);
    add_sample(16'h0000);
    add_sample(16'h8000);
    add_sample(16'h4000);
    // Mix over one is fully wet; zero threshold: x > 0 uses the decaying branch.
    add_cfg(esc_pkg::CfgThreshold, 16'h0000);
    add_cfg(esc_pkg::CfgMix, 16'hffff);
    add_sample(16'h7fff);
    add_sample(16'h0001);
    add_sample(16'h0000);
    add_sample(16'hffff);
    add_sample(16'h8000);
    // Half mix around a mid threshold, both sides of the step.
    add_cfg(esc_pkg::CfgThreshold, 16'h4000);
    add_cfg(esc_pkg::CfgMix, 16'h4000);
    add_sample(16'h4000);
    add_sample(16'h4001);
    add_sample(16'h3fff);
    add_sample(16'hc000);
    add_sample(16'h3039);

    // Random phases, each with its own register settings.
    for (int ph = 0; ph < 8; ph++) begin
      idle_mode = (ph < 6) && (ph != 3);
      case ($urandom_range(0, 3))
        0:       thr_pick = '0;
        1:       thr_pick = '1;
        default: thr_pick = Frac'($urandom_range(0, 32767));
      endcase
      case ($urandom_range(0, 4))
        0:       mix_pick = 16'h0000;
        1:       mix_pick = 16'h8000;
        2:       mix_pick = 16'($urandom_range(32769, 65535));
        default: mix_pick = 16'($urandom_range(0, 32768));
      endcase
      if (ph == 0) begin
        thr_pick = '0;
        mix_pick = 16'h8000;
      end else if (ph == 1) begin
        thr_pick = '1;
        mix_pick = 16'hffff;
      end
      // The unused top bit of the threshold is written at random.
      add_cfg(esc_pkg::CfgThreshold, {1'($urandom_range(0, 1)), thr_pick});
      add_cfg(esc_pkg::CfgMix, mix_pick);
      cnt = 190;
      for (int i = 0; i < cnt; i++) begin
        case ($urandom_range(0, 9))
          0: begin
            case ($urandom_range(0, 3))
              0:       s = 16'h8000;
              1:       s = 16'h7fff;
              2:       s = 16'h0000;
              default: s = 16'hffff;
            endcase
          end
          1, 2:    s = {1'b0, thr_pick} + 16'($urandom_range(0, 4)) - 16'd2;
          default: s = 16'($urandom_range(0, 65535));
        endcase
        add_sample(s);
        if (i == cnt / 2) begin
          add_drain();
        end
      end
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (plan_q.size() != 0 || s_axis_tvalid || cfg_we_i) begin
      @(posedge clk_i);
    end
    cnt = 0;
    while (blended_q.size() != 0 && cnt < 2000) begin
      @(posedge clk_i);
      cnt++;
    end
    repeat (esc_pkg::PipeDepth + 4) @(posedge clk_i);
    if (blended_q.size() != 0) begin
      report_mismatch($sformatf("%0d expected samples never came out",
                                blended_q.size()));
    end
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(LimitCycles * 10);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* exponential_soft_clipper_mix_top.f */
sv/esc_pkg.sv
sv/esc_index.sv
sv/esc_exp.sv
sv/esc_blend.sv
sv/exponential_soft_clipper_mix_top.sv
test/tb_top.sv
